// ===== rtl/core/coalescing_range_set_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the coalescing range set unit.
// Checks vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef COALESCING_RANGE_SET_UNIT_ASSERT_SVH
`define COALESCING_RANGE_SET_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CRSU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define CRSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRSU_ASSERT(lbl, clk, rstn, prop, msg)
`define CRSU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/crsu_pkg.sv =====
// ----------------------------------------------------------------------------
// crsu_pkg
// Shared codes and control types of the coalescing range set unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package crsu_pkg;
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_CONTAINS = 3'd1;
  localparam logic [2:0] OP_OVERLAP  = 3'd2;
  localparam logic [2:0] OP_REMOVE   = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic issue;
    logic proc;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic last;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/coalescing_range_set_unit.sv =====
// Coalescing range set unit.
// The block keeps a sorted table of disjoint address ranges, no two of which
// overlap or touch. A request is offered on op_i, range_start_i and
// range_length_i with start_i; it is taken as a transaction at a clock edge
// where start_i is high and busy_o is low. The answer appears for exactly
// one cycle with done_o high, carrying status_o, out_base_o, out_size_o,
// range_count_o and total_bytes_o. The receiver cannot stall the block, so
// it must capture the result in the cycle that done_o marks.
// After acceptance the sequencer passes through CHECK, SCAN, DRAIN and
// FLUSH for a request that walks the table, one SCAN step per stored range;
// clear, bad requests and an empty table go from CHECK to FLUSH. done_o is
// registered from FLUSH. The walk reads one entry per cycle through the
// single read port of the range memory; merged and shifted entries are
// written back through the write port behind the read pointer. A new
// request may be accepted in the cycle done_o is high, not while busy_o is.
// Reset empties the table at once; no clearing pass is needed because only
// entries below the range count are ever read.
// ----------------------------------------------------------------------------
// coalescing_range_set_unit
// Top level: sequencer and range table datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "coalescing_range_set_unit_assert.svh"
module coalescing_range_set_unit #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned ADDR_BITS  = 32,
  localparam int unsigned IW = $clog2(MAX_RANGES),
  localparam int unsigned CW = $clog2(MAX_RANGES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [2:0]    op_i,
  input  wire logic [31:0]   range_start_i,
  input  wire logic [31:0]   range_length_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [31:0]        out_base_o,
  output logic [32:0]        out_size_o,
  output logic [CW-1:0]      range_count_o,
  output logic [32:0]        total_bytes_o
);
  import crsu_pkg::*;

  cmd_t          cmd;
  stat_t         stat;
  logic [IW-1:0] rd_addr;

  crsu_ctrl #(.IW(IW)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  crsu_dp #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_BITS  (ADDR_BITS),
    .IW         (IW),
    .CW         (CW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .op_i           (op_i),
    .range_start_i  (range_start_i),
    .range_length_i (range_length_i),
    .stat_o         (stat),
    .status_o       (status_o),
    .out_base_o     (out_base_o),
    .out_size_o     (out_size_o),
    .range_count_o  (range_count_o),
    .total_bytes_o  (total_bytes_o)
  );

  // A result is only reported once the sequencer has returned to idle.
  `CRSU_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "result while busy")
  // An accepted transaction always occupies the unit in the next cycle.
  `CRSU_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "start lost")
  // Results are single-cycle strobes.
  `CRSU_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result repeated")
  // The table never reports more ranges than it can hold.
  `CRSU_ASSERT(a_count_max, clk_i, rst_ni, done_o |-> (range_count_o <= CW'(MAX_RANGES)), "range count overflow")
endmodule
`default_nettype wire

// ===== rtl/core/crsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// crsu_ctrl
// Sequencer: walks the stored entries one read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crsu_ctrl #(
  parameter int unsigned IW = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire crsu_pkg::stat_t stat_i,
  output crsu_pkg::cmd_t       cmd_o,
  output logic [IW-1:0]        rd_addr_o,
  output logic                 busy_o,
  output logic                 done_o
);
  import crsu_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          proc_q, done_q;
  logic          issue;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    issue   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (start_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.skip ? S_FLUSH : S_SCAN;
      end
      S_SCAN: begin
        issue = 1'b1;
        if (stat_i.last) state_d = S_DRAIN;
        else idx_d = idx_q + 1'b1;
      end
      S_DRAIN: state_d = S_FLUSH;
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      proc_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      proc_q  <= issue;
      done_q  <= (state_q == S_FLUSH);
    end
  end

  assign cmd_o.load   = (state_q == S_IDLE) && start_i;
  assign cmd_o.issue  = issue;
  assign cmd_o.proc   = proc_q;
  assign cmd_o.finish = (state_q == S_FLUSH);
  assign rd_addr_o    = idx_q;
  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
endmodule
`default_nettype wire

// ===== rtl/core/crsu_dp.sv =====
// ----------------------------------------------------------------------------
// crsu_dp
// Datapath: range table memory, merge accumulator and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module crsu_dp #(
  parameter int unsigned MAX_RANGES = 64,
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned IW         = 6,
  parameter int unsigned CW         = 7
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire crsu_pkg::cmd_t cmd_i,
  input  wire logic [IW-1:0]  rd_addr_i,
  input  wire logic [2:0]     op_i,
  input  wire logic [31:0]    range_start_i,
  input  wire logic [31:0]    range_length_i,
  output crsu_pkg::stat_t     stat_o,
  output logic [1:0]          status_o,
  output logic [31:0]         out_base_o,
  output logic [32:0]         out_size_o,
  output logic [CW-1:0]       range_count_o,
  output logic [32:0]         total_bytes_o
);
  import crsu_pkg::*;

  localparam logic [64:0] SPACE = 65'd1 << ADDR_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_RANGES);

  logic [31:0] mem_base [MAX_RANGES];
  logic [32:0] mem_size [MAX_RANGES];
  logic [31:0] rd_base_q;
  logic [32:0] rd_size_q;

  logic [2:0]    op_q;
  logic [31:0]   a_q;
  logic [33:0]   ne_q;
  logic          zlen_q;
  logic [CW-1:0] cnt_q, cnt_d, k_q, w_q;
  logic [32:0]   cov_q, cov_d;
  logic [31:0]   acc_b_q;
  logic [33:0]   acc_e_q;
  logic          placed_q, merged_q, abort_q, found_q, carry_v_q;
  logic [31:0]   carry_b_q, res_b_q;
  logic [32:0]   carry_s_q;
  logic [33:0]   res_e_q;

  logic [33:0] re, ie;
  logic [31:0] ib;
  logic        bad, full, we;
  logic [31:0] wb;
  logic [32:0] ws;
  logic [33:0] dsz;
  logic [1:0]  st;
  logic [31:0] ob;
  logic [32:0] os;

  assign re   = {2'b0, rd_base_q} + {1'b0, rd_size_q};
  assign full = (cnt_q == FULL_CNT);
  assign ib   = (rd_base_q > a_q) ? rd_base_q : a_q;
  assign ie   = (re < ne_q) ? re : ne_q;

  always_comb begin
    bad = 1'b0;
    case (op_q) inside
      OP_INSERT: bad = zlen_q || ({33'b0, a_q} >= SPACE) || ({31'b0, ne_q} > SPACE);
      OP_OVERLAP: bad = zlen_q;
      OP_CONTAINS, OP_REMOVE, OP_CLEAR: bad = 1'b0;
      default: bad = 1'b1;
    endcase
  end

  assign stat_o.skip = bad || (op_q == OP_CLEAR) || (cnt_q == '0);
  assign stat_o.last = (CW'(rd_addr_i) == cnt_q - 1'b1);

  // Write port: shifted entries during the walk, the final entry at finish.
  always_comb begin
    we = 1'b0;
    wb = carry_b_q;
    ws = carry_s_q;
    if (cmd_i.proc && !bad) begin
      if (op_q == OP_INSERT && !abort_q && placed_q) begin
        we = 1'b1;
      end else if (op_q == OP_INSERT && !abort_q && re >= {2'b0, a_q}
                   && {2'b0, rd_base_q} > ne_q && (merged_q || !full)) begin
        we = 1'b1;
        wb = acc_b_q;
        ws = 33'(acc_e_q - {2'b0, acc_b_q});
      end else if (op_q == OP_REMOVE && found_q) begin
        we = 1'b1;
        wb = rd_base_q;
        ws = rd_size_q;
      end
    end else if (cmd_i.finish && op_q == OP_INSERT && !bad && !abort_q) begin
      if (placed_q) begin
        we = carry_v_q;
      end else if (merged_q || !full) begin
        we = 1'b1;
        wb = acc_b_q;
        ws = 33'(acc_e_q - {2'b0, acc_b_q});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_base[w_q[IW-1:0]] <= wb;
      mem_size[w_q[IW-1:0]] <= ws;
    end
    if (cmd_i.issue) begin
      rd_base_q <= mem_base[rd_addr_i];
      rd_size_q <= mem_size[rd_addr_i];
    end
  end

  // Result of the request at finish.
  always_comb begin
    st    = ST_OK;
    ob    = '0;
    os    = '0;
    cnt_d = cnt_q;
    cov_d = cov_q;
    dsz   = acc_e_q - {2'b0, acc_b_q};
    if (bad) begin
      st = ST_BAD;
    end else begin
      case (op_q) inside
        OP_INSERT: begin
          if (abort_q || (!placed_q && !merged_q && full)) begin
            st = ST_FULL;
          end else begin
            ob    = acc_b_q;
            os    = dsz[32:0];
            cnt_d = cnt_q - k_q + 1'b1;
            cov_d = cov_q + dsz[32:0];
          end
        end
        OP_CONTAINS, OP_OVERLAP, OP_REMOVE: begin
          if (found_q) begin
            ob  = res_b_q;
            dsz = res_e_q - {2'b0, res_b_q};
            os  = dsz[32:0];
            if (op_q == OP_REMOVE) begin
              cnt_d = cnt_q - 1'b1;
              cov_d = cov_q - dsz[32:0];
            end
          end else begin
            st = ST_MISS;
          end
        end
        OP_CLEAR: begin
          cnt_d = '0;
          cov_d = '0;
        end
        default: st = ST_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cov_q     <= '0;
      op_q      <= OP_CLEAR;
      placed_q  <= 1'b0;
      merged_q  <= 1'b0;
      abort_q   <= 1'b0;
      found_q   <= 1'b0;
      carry_v_q <= 1'b0;
      k_q       <= '0;
      w_q       <= '0;
    end else if (cmd_i.load) begin
      op_q      <= op_i;
      placed_q  <= 1'b0;
      merged_q  <= 1'b0;
      abort_q   <= 1'b0;
      found_q   <= 1'b0;
      carry_v_q <= 1'b0;
      k_q       <= '0;
      w_q       <= '0;
    end else if (cmd_i.proc && !bad) begin
      case (op_q)
        OP_INSERT: begin
          if (abort_q) begin
            abort_q <= 1'b1;
          end else if (placed_q) begin
            w_q <= w_q + 1'b1;
          end else if (re < {2'b0, a_q}) begin
            w_q <= w_q + 1'b1;
          end else if ({2'b0, rd_base_q} <= ne_q) begin
            merged_q <= 1'b1;
            k_q      <= k_q + 1'b1;
            cov_q    <= cov_q - rd_size_q;
          end else if (!merged_q && full) begin
            abort_q <= 1'b1;
          end else begin
            placed_q  <= 1'b1;
            carry_v_q <= 1'b1;
            w_q       <= w_q + 1'b1;
          end
        end
        OP_CONTAINS: begin
          if (!found_q && rd_base_q <= a_q && {2'b0, a_q} < re) found_q <= 1'b1;
        end
        OP_OVERLAP: begin
          if (!found_q && re > {2'b0, a_q} && {2'b0, rd_base_q} < ne_q) found_q <= 1'b1;
        end
        OP_REMOVE: begin
          if (!found_q && rd_base_q == a_q) found_q <= 1'b1;
          else w_q <= w_q + 1'b1;
        end
        default: found_q <= found_q;
      endcase
    end else if (cmd_i.finish) begin
      cnt_q <= cnt_d;
      cov_q <= cov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q     <= range_start_i;
      ne_q    <= {2'b0, range_start_i} + {2'b0, range_length_i};
      zlen_q  <= (range_length_i == '0);
      acc_b_q <= range_start_i;
      acc_e_q <= {2'b0, range_start_i} + {2'b0, range_length_i};
    end else if (cmd_i.proc) begin
      if (op_q == OP_INSERT && !placed_q && re >= {2'b0, a_q}
          && {2'b0, rd_base_q} <= ne_q) begin
        if (rd_base_q < acc_b_q) acc_b_q <= rd_base_q;
        if (re > acc_e_q) acc_e_q <= re;
      end
      if (op_q == OP_INSERT) begin
        carry_b_q <= rd_base_q;
        carry_s_q <= rd_size_q;
      end
      if (!found_q) begin
        if (op_q == OP_OVERLAP) begin
          res_b_q <= ib;
          res_e_q <= ie;
        end else begin
          res_b_q <= rd_base_q;
          res_e_q <= re;
        end
      end
    end
    if (cmd_i.finish) begin
      status_o      <= st;
      out_base_o    <= ob;
      out_size_o    <= os;
      range_count_o <= cnt_d;
      total_bytes_o <= cov_d;
    end
  end
endmodule
`default_nettype wire

// ===== tb/coalescing_range_set_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_range_set_checker
// Watches the request and result ports of the range set unit, predicts each
// answer from a private copy of the range table and compares field by field.
// ----------------------------------------------------------------------------
module coalescing_range_set_checker
  import crsu_pkg::*;
#(
  parameter int unsigned MAX_RANGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] range_start_i,
  input  logic [31:0] range_length_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] out_base_i,
  input  logic [32:0] out_size_i,
  input  logic [6:0]  range_count_i,
  input  logic [32:0] total_bytes_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          answers_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] base;
    logic [32:0] size;
    logic [6:0]  count;
    logic [32:0] total;
  } answer_t;

  answer_t answer_q[$];

  // Private copy of the table, sorted by base.
  logic [32:0] tbl_base [MAX_RANGES];
  logic [32:0] tbl_size [MAX_RANGES];
  int          tbl_count;
  logic [32:0] tbl_total;

  function automatic answer_t make_answer(logic [1:0] st, logic [32:0] b, logic [32:0] s);
    answer_t a;
    a.status = st;
    a.base   = b[31:0];
    a.size   = s;
    a.count  = 7'(tbl_count);
    a.total  = tbl_total;
    return a;
  endfunction

  function automatic answer_t apply_request(logic [2:0] op, logic [31:0] addr,
                                            logic [31:0] len);
    logic [33:0] nb, ne, mb, me, sb, se, qe, ib, ie;
    int i, j, k;
    nb = {2'b0, addr};
    ne = nb + len;
    case (op)
      OP_INSERT: begin
        if (len == 0 || ne > 34'h1_0000_0000) return make_answer(ST_BAD, 0, 0);
        i = 0;
        while (i < tbl_count && tbl_base[i] + tbl_size[i] < nb) i++;
        j = i;
        while (j < tbl_count && tbl_base[j] <= ne) j++;
        if (j == i && tbl_count >= MAX_RANGES) return make_answer(ST_FULL, 0, 0);
        mb = nb;
        me = ne;
        if (j > i) begin
          if (tbl_base[i] < mb) mb = tbl_base[i];
          if (tbl_base[j-1] + tbl_size[j-1] > me) me = tbl_base[j-1] + tbl_size[j-1];
          for (k = i; k < j; k++) tbl_total -= tbl_size[k];
          // Close the gap left by the absorbed entries.
          for (k = j; k < tbl_count; k++) begin
            tbl_base[i+1+k-j] = tbl_base[k];
            tbl_size[i+1+k-j] = tbl_size[k];
          end
          tbl_count = tbl_count - (j - i) + 1;
        end else begin
          for (k = tbl_count; k > i; k--) begin
            tbl_base[k] = tbl_base[k-1];
            tbl_size[k] = tbl_size[k-1];
          end
          tbl_count++;
        end
        tbl_base[i] = mb[32:0];
        tbl_size[i] = 33'(me - mb);
        tbl_total += 33'(me - mb);
        return make_answer(ST_OK, mb[32:0], 33'(me - mb));
      end
      OP_CONTAINS: begin
        for (i = 0; i < tbl_count; i++)
          if (tbl_base[i] <= nb && nb < tbl_base[i] + tbl_size[i])
            return make_answer(ST_OK, tbl_base[i], tbl_size[i]);
        return make_answer(ST_MISS, 0, 0);
      end
      OP_OVERLAP: begin
        if (len == 0) return make_answer(ST_BAD, 0, 0);
        qe = ne;
        for (i = 0; i < tbl_count; i++) begin
          sb = tbl_base[i];
          se = sb + tbl_size[i];
          if (se > nb && sb < qe) begin
            ib = (sb > nb) ? sb : nb;
            ie = (se < qe) ? se : qe;
            return make_answer(ST_OK, ib[32:0], 33'(ie - ib));
          end
        end
        return make_answer(ST_MISS, 0, 0);
      end
      OP_REMOVE: begin
        for (i = 0; i < tbl_count; i++)
          if (tbl_base[i] == nb) begin
            sb = tbl_base[i];
            se = tbl_size[i];
            for (k = i; k < tbl_count - 1; k++) begin
              tbl_base[k] = tbl_base[k+1];
              tbl_size[k] = tbl_size[k+1];
            end
            tbl_count--;
            tbl_total -= se[32:0];
            return make_answer(ST_OK, sb[32:0], se[32:0]);
          end
        return make_answer(ST_MISS, 0, 0);
      end
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_total = 0;
        return make_answer(ST_OK, 0, 0);
      end
      default: return make_answer(ST_BAD, 0, 0);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      tbl_count    = 0;
      tbl_total    = 0;
      fail_count_o <= 0;
      answers_o    <= 0;
      pending_o    <= 0;
      answer_q.delete();
    end else begin
      // The result is checked before a request taken in the same cycle.
      if (done_i) begin
        got = '{status_i, out_base_i, out_size_i, range_count_i, total_bytes_i};
        answers_o <= answers_o + 1;
        if (answer_q.size() == 0) begin
          $display("%0t: result with no request pending, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected st=%0d base=%h size=%h cnt=%0d tot=%h",
                     $time, want.status, want.base, want.size, want.count, want.total);
            $display("%0t:          actual   st=%0d base=%h size=%h cnt=%0d tot=%h",
                     $time, got.status, got.base, got.size, got.count, got.total);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        answer_q.push_back(apply_request(op_i, range_start_i, range_length_i));
      pending_o <= answer_q.size();
    end
  end

endmodule

// ===== tb/tb_coalescing_range_set_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_range_set_unit
// Drives directed and random insert, lookup, remove and clear requests into
// the range set unit; a checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_coalescing_range_set_unit;
  import crsu_pkg::*;

  localparam int unsigned NUM_RANDOM = 1465;
  // Worst request walks 64 entries plus overhead; allow a long sender gap too.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  op_i = OP_CLEAR;
  logic [31:0] range_start_i = '0;
  logic [31:0] range_length_i = '0;
  logic        busy_o, done_o;
  logic [1:0]  status_o;
  logic [31:0] out_base_o;
  logic [32:0] out_size_o;
  logic [6:0]  range_count_o;
  logic [32:0] total_bytes_o;

  int fail_count, pending, answers;
  int cycles = 0;
  int inserts = 0, lookups = 0, removes = 0, clears = 0;

  // Recently used bases, so that lookups and removes often hit.
  logic [31:0] recent_base[$];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  coalescing_range_set_unit u_top (
    .clk_i, .rst_ni, .start_i, .op_i, .range_start_i, .range_length_i,
    .busy_o, .done_o, .status_o, .out_base_o, .out_size_o, .range_count_o,
    .total_bytes_o
  );

  coalescing_range_set_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .range_start_i,
    .range_length_i, .done_i(done_o), .status_i(status_o), .out_base_i(out_base_o),
    .out_size_i(out_size_o), .range_count_i(range_count_o),
    .total_bytes_i(total_bytes_o), .fail_count_o(fail_count), .pending_o(pending),
    .answers_o(answers)
  );

  // A watchdog ends a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_coalescing_range_set_unit: FAIL");
      $finish;
    end
  end

  // Offers one transaction and holds it until the unit takes it.
  task automatic send_request(logic [2:0] op, logic [31:0] addr, logic [31:0] len);
    start_i        <= 1'b1;
    op_i           <= op;
    range_start_i  <= addr;
    range_length_i <= len;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (op) inside
      OP_INSERT: begin
        inserts++;
        recent_base.push_back(addr);
        if (recent_base.size() > 32) void'(recent_base.pop_front());
      end
      OP_CONTAINS, OP_OVERLAP: lookups++;
      OP_REMOVE: removes++;
      OP_CLEAR: clears++;
      default: ;
    endcase
  endtask

  // Idle time between transactions: mostly none or short, sometimes long.
  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) return;
    start_i <= 1'b0;
    n = (n < 92) ? $urandom_range(1, 4) : $urandom_range(10, 120);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr(int mode);
    logic [31:0] b;
    case (mode)
      0: b = $urandom;
      1: b = (recent_base.size() != 0)
             ? recent_base[$urandom_range(0, recent_base.size() - 1)] : 32'h0;
      default: b = {16'h0, 4'h0, 12'($urandom_range(0, 4095))};
    endcase
    return b;
  endfunction

  task automatic random_request();
    logic [2:0]  op;
    logic [31:0] addr, len;
    int sel, mode;
    sel  = $urandom_range(0, 99);
    mode = $urandom_range(0, 9);
    // Most traffic lands in a small window so ranges touch and merge often.
    addr = pick_addr(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
    if ($urandom_range(0, 9) == 0) len = $urandom;
    else len = $urandom_range(1, 96);
    if ($urandom_range(0, 49) == 0) len = 0;
    if (sel < 40) op = OP_INSERT;
    else if (sel < 60) op = OP_CONTAINS;
    else if (sel < 75) op = OP_OVERLAP;
    else if (sel < 94) begin
      op = OP_REMOVE;
      addr = pick_addr(mode < 8 ? 1 : 2);
    end else if (sel < 96) op = OP_CLEAR;
    else op = 3'($urandom_range(5, 7));
    // Near the top of the address space now and then.
    if (sel % 17 == 0) addr = 32'hFFFF_FFFF - $urandom_range(0, 200);
    send_request(op, addr, len);
  endtask

  initial begin
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bad requests, extremes, merging, misses and a full table.
    send_request(OP_CONTAINS, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'h100, 32'h0);
    send_request(OP_OVERLAP, 32'h100, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h2);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h1);
    send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_CONTAINS, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_OVERLAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 32'h0, 32'h0);
    send_request(OP_REMOVE, 32'h0, 32'h0);
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'h10, 32'h10);
    send_request(OP_INSERT, 32'h30, 32'h10);
    send_request(OP_INSERT, 32'h20, 32'h10);
    send_request(OP_OVERLAP, 32'h0, 32'h18);
    send_request(OP_CLEAR, 32'h0, 32'h0);
    // Fill the table with separated ranges, then try one more.
    for (k = 0; k < 65; k++) send_request(OP_INSERT, 32'(k * 4), 32'h1);
    send_request(OP_INSERT, 32'h1, 32'h1);
    send_request(OP_CONTAINS, 32'hFC, 32'h0);
    send_request(OP_CLEAR, 32'h0, 32'h0);

    for (k = 0; k < NUM_RANDOM; k++) begin
      random_request();
      // Pause once until the unit has drained every answer.
      if (k == NUM_RANDOM / 2) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end else begin
        sender_gap();
      end
    end
    start_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("covered %0d inserts, %0d lookups, %0d removes, %0d clears; %0d results",
             inserts, lookups, removes, clears, answers);
    if (fail_count == 0) begin
      $display("tb_coalescing_range_set_unit: PASS");
    end else begin
      $display("tb_coalescing_range_set_unit: FAIL");
    end
    $finish;
  end

endmodule
